/* hw/rtl/baudot_teletype_transmitter_defines.svh */
// assertion macros for the baudot teletype transmitter
// clocked on clk_i and disabled while rst_ni is low; empty under synthesis
`ifndef BAUDOT_TELETYPE_TRANSMITTER_DEFINES_SVH
`define BAUDOT_TELETYPE_TRANSMITTER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define BTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be true at a clock edge out of reset
`define BTT_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define BTT_ASSERT(label, prop, msg)
`define BTT_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* hw/rtl/btt_pkg.sv */
// shared types and constants of the baudot teletype transmitter
// no dependencies
package btt_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_BIT_PERIOD       = 2'd0;
  localparam logic [1:0] REG_FIRST_BIT_PERIOD = 2'd1;
  localparam logic [1:0] REG_LETTERS_SHIFT    = 2'd2;
  localparam logic [1:0] REG_FIGURES_SHIFT    = 2'd3;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;

  // configuration reset values
  localparam logic [15:0] BIT_PERIOD_RST       = 16'd2750;
  localparam logic [15:0] FIRST_BIT_PERIOD_RST = 16'd4125;
  localparam logic [4:0]  LETTERS_SHIFT_RST    = 5'd27;
  localparam logic [4:0]  FIGURES_SHIFT_RST    = 5'd29;

  // ascii codes seen by the command filter
  localparam logic [7:0] ASCII_BACKSLASH = 8'h5C;
  localparam logic [7:0] ASCII_NEWLINE   = 8'h0A;

  // character code layout
  localparam int unsigned CodeWidth = 7;
  localparam int unsigned FrameWidth = 5;
  localparam int unsigned CodeLettersBit = 5;
  localparam int unsigned CodeFiguresBit = 6;

  // operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_PUSH = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  typedef struct packed {
    op_e                  kind;
    logic [CodeWidth-1:0] code;
  } btt_op_t;

  // configuration write bundle
  typedef struct packed {
    logic                     we;
    logic [CfgIndexWidth-1:0] index;
    logic [CfgDataWidth-1:0]  data;
  } btt_cfg_wr_t;

endpackage

/* hw/rtl/btt_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module btt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/btt_front.sv */
// front end: accepts items, filters command text, classifies into operations
// depends on btt_pkg
module btt_front import btt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [CodeWidth-1:0] char_code_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output btt_op_t              q_op_o
);

  logic accept;
  logic in_command_q, in_command_d;
  logic cmd_now;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // classify the item and track command mode
  always_comb begin
    in_command_d = in_command_q;
    cmd_now      = in_command_q;
    q_op_o.kind  = OP_NOP;
    q_op_o.code  = char_code_i;
    if (mode_i) begin
      q_op_o.kind = OP_TICK;
    end else begin
      if (!in_command_q) begin
        if (rx_byte_i == ASCII_BACKSLASH) begin
          cmd_now = 1'b1;
        end else begin
          q_op_o.kind = OP_PUSH;
        end
      end
      in_command_d = cmd_now && (rx_byte_i != ASCII_NEWLINE);
    end
  end

  assign q_push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_command_q <= 1'b0;
    end else if (accept) begin
      in_command_q <= in_command_d;
    end
  end

endmodule

/* hw/rtl/btt_queue.sv */
// two-entry operation queue between the front and the back
// depends on btt_pkg and the assertion macros
`include "baudot_teletype_transmitter_defines.svh"

module btt_queue import btt_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  btt_op_t op_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output btt_op_t op_o
);

  localparam logic [1:0] QueueDepth = 2'd2;

  btt_op_t    slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == QueueDepth);
  assign valid_o = (count_q != 2'd0);
  assign op_o    = slot_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  `BTT_ASSERT(a_count_range, count_q <= QueueDepth, "queue count out of range")
  `BTT_ASSERT_NEVER(a_pop_empty, pop_i && (count_q == 2'd0), "pop from empty queue")
  `BTT_ASSERT_NEVER(a_push_full, push_i && (count_q == QueueDepth), "push into full queue")

endmodule

/* hw/rtl/btt_back.sv */
// back end: ring buffer, bit timer, frame sequencer, config and result register
// depends on btt_pkg, btt_ram and the assertion macros
`include "baudot_teletype_transmitter_defines.svh"

module btt_back import btt_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  btt_cfg_wr_t cfg_i,
  input  logic        op_valid_i,
  input  btt_op_t     op_i,
  output logic        op_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        line_level_o,
  output logic        overflow_o,
  output logic        frame_busy_o
);

  localparam int unsigned PtrW = $clog2(BUFFER_DEPTH);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(BUFFER_DEPTH - 1);
  localparam logic [2:0] SlotLast = 3'd6;

  typedef enum logic [1:0] {
    CASE_NONE    = 2'd0,
    CASE_LETTERS = 2'd1,
    CASE_FIGURES = 2'd2
  } case_e;

  // configuration
  logic [15:0] bit_period_q, first_bit_period_q;
  logic [4:0]  letters_shift_q, figures_shift_q;

  // ring buffer pointers and prefetched head entry
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]      wr_inc, rd_inc;
  logic [CodeWidth-1:0] head_q, head_d;
  logic                 head_valid_q, head_valid_d;
  logic                 rd_pending_q, rd_pending_d;

  // timer and sequencer
  logic [15:0]           tick_q, tick_d;
  logic                  first_q, first_d;
  logic [2:0]            slot_q, slot_d;
  logic [FrameWidth-1:0] fbits_q, fbits_d;
  logic                  fvalid_q, fvalid_d;
  case_e                 case_q, case_d;
  logic                  coil_q, coil_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic line_q, ovf_q, busy_q;
  logic dropped;

  // ram port
  logic                 ram_we, ram_re;
  logic [CodeWidth-1:0] ram_rdata;

  logic        fire;
  logic        bit_evt;
  logic [15:0] compare;
  logic        lett, figs, match;

  assign fire     = op_valid_i && (!out_valid_q || !out_stall_i);
  assign op_pop_o = fire;

  assign wr_inc = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
  assign rd_inc = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);

  btt_ram #(
    .WIDTH (CodeWidth),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (op_i.code),
    .re_i    (ram_re),
    .raddr_i (rd_inc),
    .rdata_o (ram_rdata)
  );

  // execute one operation
  always_comb begin
    wr_ptr_d     = wr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    rd_pending_d = 1'b0;
    tick_d       = tick_q;
    first_d      = first_q;
    slot_d       = slot_q;
    fbits_d      = fbits_q;
    fvalid_d     = fvalid_q;
    case_d       = case_q;
    coil_d       = coil_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    dropped      = 1'b0;
    bit_evt      = 1'b0;
    compare      = first_q ? first_bit_period_q : bit_period_q;
    lett         = head_q[CodeLettersBit];
    figs         = head_q[CodeFiguresBit];
    match        = ((case_q == CASE_LETTERS) && lett) || ((case_q == CASE_FIGURES) && figs);

    // refill of the head entry after a pop
    if (rd_pending_q) begin
      head_d       = ram_rdata;
      head_valid_d = 1'b1;
    end

    if (fire) begin
      case (op_i.kind)
        OP_PUSH: begin
          if (wr_inc == rd_ptr_q) begin
            dropped = 1'b1;
          end else begin
            ram_we   = 1'b1;
            wr_ptr_d = wr_inc;
            // empty buffer: the new entry becomes the head at once
            if (rd_ptr_q == wr_ptr_q) begin
              head_d       = op_i.code;
              head_valid_d = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (tick_q >= compare) begin
            tick_d  = '0;
            bit_evt = 1'b1;
          end else begin
            tick_d = tick_q + 16'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // one bit period of the sequencer
    if (bit_evt) begin
      if (slot_q == 3'd0) begin
        if (rd_ptr_q == wr_ptr_q) begin
          fvalid_d = 1'b0;
        end else begin
          if (!match && lett) begin
            fbits_d = letters_shift_q;
            case_d  = CASE_LETTERS;
          end else if (!match && figs) begin
            fbits_d = figures_shift_q;
            case_d  = CASE_FIGURES;
          end else begin
            fbits_d      = head_q[FrameWidth-1:0];
            rd_ptr_d     = rd_inc;
            head_valid_d = 1'b0;
            if (rd_inc != wr_ptr_q) begin
              ram_re       = 1'b1;
              rd_pending_d = 1'b1;
            end
          end
          fvalid_d = 1'b1;
        end
      end
      slot_d = (slot_q == SlotLast) ? 3'd0 : slot_q + 3'd1;
      if (fvalid_d) begin
        if (slot_q == 3'd0) begin
          coil_d  = 1'b0;
          first_d = 1'b1;
        end else if (slot_q == SlotLast) begin
          // stop bit; the slot counter restarts past slot zero
          coil_d   = 1'b1;
          fvalid_d = 1'b0;
          slot_d   = 3'd1;
        end else begin
          first_d = 1'b0;
          coil_d  = fbits_d[slot_q - 3'd1];
        end
      end
    end

    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q       <= BIT_PERIOD_RST;
      first_bit_period_q <= FIRST_BIT_PERIOD_RST;
      letters_shift_q    <= LETTERS_SHIFT_RST;
      figures_shift_q    <= FIGURES_SHIFT_RST;
      wr_ptr_q           <= '0;
      rd_ptr_q           <= '0;
      head_valid_q       <= 1'b0;
      rd_pending_q       <= 1'b0;
      tick_q             <= '0;
      first_q            <= 1'b0;
      slot_q             <= '0;
      fbits_q            <= '0;
      fvalid_q           <= 1'b0;
      case_q             <= CASE_NONE;
      coil_q             <= 1'b1;
      out_valid_q        <= 1'b0;
    end else begin
      if (cfg_i.we) begin
        unique case (cfg_i.index)
          REG_BIT_PERIOD:       bit_period_q       <= cfg_i.data;
          REG_FIRST_BIT_PERIOD: first_bit_period_q <= cfg_i.data;
          REG_LETTERS_SHIFT:    letters_shift_q    <= cfg_i.data[FrameWidth-1:0];
          REG_FIGURES_SHIFT:    figures_shift_q    <= cfg_i.data[FrameWidth-1:0];
          default: begin
          end
        endcase
      end
      wr_ptr_q     <= wr_ptr_d;
      rd_ptr_q     <= rd_ptr_d;
      head_valid_q <= head_valid_d;
      rd_pending_q <= rd_pending_d;
      tick_q       <= tick_d;
      first_q      <= first_d;
      slot_q       <= slot_d;
      fbits_q      <= fbits_d;
      fvalid_q     <= fvalid_d;
      case_q       <= case_d;
      coil_q       <= coil_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    if (fire) begin
      line_q <= coil_d;
      ovf_q  <= dropped;
      busy_q <= fvalid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = line_q;
  assign overflow_o   = ovf_q;
  assign frame_busy_o = busy_q;

  `BTT_ASSERT(a_slot_range, slot_q <= SlotLast, "bit slot out of range")
  `BTT_ASSERT(a_head_ready, bit_evt && slot_q == '0 && rd_ptr_q != wr_ptr_q |-> head_valid_q,
              "head entry not ready at frame start")
  `BTT_ASSERT_NEVER(a_space_idle, !coil_q && !fvalid_q, "line at space with no frame")

endmodule

/* hw/rtl/baudot_teletype_transmitter.sv */
// top level of the baudot teletype transmitter
// depends on btt_pkg, btt_front, btt_queue, btt_back
//
//   channel  signals                                   direction  handshake
//   cfg      cfg_we_i cfg_index_i cfg_data_i            in         write on cfg_we_i
//   in       mode_i rx_byte_i char_code_i               in         in_valid_i / in_stall_o
//   out      line_level_o overflow_o frame_busy_o       out        out_valid_o / out_stall_i
//
// one item per cycle sustained while out_stall_i is low; each item's result passes through
// the queue entry and then the back end's result register before it is valid.
// a character pop refetches the next ring buffer entry through the registered ram read
// port and the head register, well ahead of the next frame start.
// reset: line at mark, buffer empty, timer and sequencer at zero, config at defaults.
// output stall holds the result register; the two-entry queue then fills and
// raises in_stall_o.
module baudot_teletype_transmitter import btt_pkg::*; #(
  parameter int unsigned BUFFER_DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     mode_i,
  input  logic [7:0]               rx_byte_i,
  input  logic [CodeWidth-1:0]     char_code_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     line_level_o,
  output logic                     overflow_o,
  output logic                     frame_busy_o
);

  btt_cfg_wr_t cfg_wr;
  btt_op_t     front_op, back_op;
  logic        q_push, q_full, q_pop, q_valid;

  assign cfg_wr.we    = cfg_we_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // item intake and classification
  btt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .rx_byte_i   (rx_byte_i),
    .char_code_i (char_code_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_op_o      (front_op)
  );

  // decoupling queue
  btt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .op_o    (back_op)
  );

  // buffer, timing and line drive
  btt_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .op_valid_i   (q_valid),
    .op_i         (back_op),
    .op_pop_o     (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_level_o (line_level_o),
    .overflow_o   (overflow_o),
    .frame_busy_o (frame_busy_o)
  );

endmodule

/* bench/tb_top.sv */
// testbench for the baudot teletype transmitter: byte and tick items in, line states out
// a line-state predictor runs beside the block; depends on btt_pkg and the rtl top
`timescale 1ns / 100ps

module tb_top;
  import btt_pkg::*;

  localparam int unsigned BUF_DEPTH   = 128;
  localparam int unsigned PTR_W       = $clog2(BUF_DEPTH);
  localparam int unsigned STOP_SLOT   = FrameWidth + 1;
  localparam int unsigned SLOT_COUNT  = STOP_SLOT + 1;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned PRINT_LIMIT = 100;
  localparam logic        MODE_BYTE   = 1'b0;
  localparam logic        MODE_TICK   = 1'b1;

  typedef enum logic [1:0] {
    CASE_NONE    = 2'd0,
    CASE_LETTERS = 2'd1,
    CASE_FIGURES = 2'd2
  } print_case_e;

  typedef struct packed {
    logic                 mode;
    logic [7:0]           rx_byte;
    logic [CodeWidth-1:0] char_code;
  } tx_item_t;

  typedef struct packed {
    logic line_level;
    logic overflow;
    logic frame_busy;
  } line_state_t;

  // block ports
  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [CfgDataWidth-1:0]  cfg_data_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     mode_i = MODE_BYTE;
  logic [7:0]               rx_byte_i = '0;
  logic [CodeWidth-1:0]     char_code_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     line_level_o;
  logic                     overflow_o;
  logic                     frame_busy_o;

  baudot_teletype_transmitter #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .rx_byte_i    (rx_byte_i),
    .char_code_i  (char_code_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .line_level_o (line_level_o),
    .overflow_o   (overflow_o),
    .frame_busy_o (frame_busy_o)
  );

  // items waiting to be sent and line states waiting to come back
  tx_item_t    byte_tick_q[$];
  line_state_t line_expect_q[$];

  // register copies
  logic [15:0]           period_cfg = BIT_PERIOD_RST;
  logic [15:0]           first_cfg  = FIRST_BIT_PERIOD_RST;
  logic [FrameWidth-1:0] ltrs_cfg   = LETTERS_SHIFT_RST;
  logic [FrameWidth-1:0] figs_cfg   = FIGURES_SHIFT_RST;

  // predictor state
  logic [CodeWidth-1:0]  code_ram [BUF_DEPTH];
  int unsigned           wr_ptr = 0;
  int unsigned           rd_ptr = 0;
  logic                  cmd_active = 1'b0;
  logic [15:0]           tick_cnt = '0;
  logic                  long_start = 1'b0;
  int unsigned           slot_idx = 0;
  logic [FrameWidth-1:0] frame_data = '0;
  logic                  frame_on = 1'b0;
  print_case_e           cur_case = CASE_NONE;
  logic                  coil = 1'b1;

  // run control
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned long_holds_asked = 0;
  int unsigned long_holds_done = 0;
  bit          sender_eager = 1'b0;
  tx_item_t    cur_item;
  int unsigned in_gap = 0;
  int unsigned in_calm_left = 0;
  int unsigned out_hold = 0;
  int unsigned out_calm_left = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("tb_top: result %0d: %s", results_seen, msg);
  endtask

  function automatic int unsigned pick_wait();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 7) return $urandom_range(1, 3);
    return $urandom_range(4, 18);
  endfunction

  // one bit period of the frame sequencer
  function automatic void advance_slot();
    logic [CodeWidth-1:0] code;
    logic                 lett;
    logic                 figs;
    logic                 match;
    if (slot_idx == 0) begin
      if (rd_ptr == wr_ptr) begin
        frame_on = 1'b0;
      end else begin
        code  = code_ram[rd_ptr[PTR_W-1:0]];
        lett  = code[CodeLettersBit];
        figs  = code[CodeFiguresBit];
        match = (cur_case == CASE_LETTERS && lett) || (cur_case == CASE_FIGURES && figs);
        // a case change costs a shift frame; the character waits for the next slot zero
        if (!match && lett) begin
          frame_data = ltrs_cfg;
          cur_case   = CASE_LETTERS;
        end else if (!match && figs) begin
          frame_data = figs_cfg;
          cur_case   = CASE_FIGURES;
        end else begin
          rd_ptr     = (rd_ptr + 1) % BUF_DEPTH;
          frame_data = code[FrameWidth-1:0];
        end
        frame_on = 1'b1;
      end
    end
    if (frame_on) begin
      if (slot_idx == 0) begin
        coil       = 1'b0;
        long_start = 1'b1;
      end else if (slot_idx < STOP_SLOT) begin
        long_start = 1'b0;
        coil       = frame_data[3'(slot_idx - 1)];
      end else begin
        coil     = 1'b1;
        frame_on = 1'b0;
        slot_idx = 0;
      end
    end
    slot_idx = (slot_idx + 1) % SLOT_COUNT;
  endfunction

  // line state that one accepted item leads to
  function automatic line_state_t predict_line(input tx_item_t it);
    line_state_t res;
    int unsigned nxt;
    logic [15:0] limit;
    res.overflow = 1'b0;
    if (it.mode == MODE_BYTE) begin
      if (!cmd_active) begin
        if (it.rx_byte == ASCII_BACKSLASH) begin
          cmd_active = 1'b1;
        end else begin
          nxt = (wr_ptr + 1) % BUF_DEPTH;
          if (nxt == rd_ptr) begin
            res.overflow = 1'b1;
          end else begin
            code_ram[wr_ptr[PTR_W-1:0]] = it.char_code;
            wr_ptr = nxt;
          end
        end
      end
      if (cmd_active && it.rx_byte == ASCII_NEWLINE) cmd_active = 1'b0;
    end else begin
      limit = long_start ? first_cfg : period_cfg;
      if (tick_cnt >= limit) begin
        tick_cnt = '0;
        advance_slot();
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    res.line_level = coil;
    res.frame_busy = frame_on;
    return res;
  endfunction

  // register writes, only while nothing is in flight
  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      REG_BIT_PERIOD:       period_cfg = val;
      REG_FIRST_BIT_PERIOD: first_cfg  = val;
      REG_LETTERS_SHIFT:    ltrs_cfg   = val[FrameWidth-1:0];
      REG_FIGURES_SHIFT:    figs_cfg   = val[FrameWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [15:0] period, input logic [15:0] first,
                              input logic [15:0] ltrs, input logic [15:0] figs);
    write_reg(REG_BIT_PERIOD, period);
    write_reg(REG_FIRST_BIT_PERIOD, first);
    write_reg(REG_LETTERS_SHIFT, ltrs);
    write_reg(REG_FIGURES_SHIFT, figs);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic queue_item(input logic mode, input logic [7:0] rx,
                            input logic [CodeWidth-1:0] code);
    tx_item_t it;
    it.mode      = mode;
    it.rx_byte   = rx;
    it.char_code = code;
    byte_tick_q.push_back(it);
  endtask

  // random phase: ticks mixed with text and escaped commands
  task automatic queue_phase(input int unsigned count, input int unsigned tick_pct,
                             input int unsigned esc_pct);
    tx_item_t    it;
    int unsigned esc_left;
    int unsigned r;
    esc_left = 0;
    repeat (count) begin
      it.mode      = MODE_BYTE;
      it.rx_byte   = 8'($urandom_range(0, 255));
      it.char_code = 7'($urandom_range(0, 127));
      if ($urandom_range(0, 99) < tick_pct) begin
        it.mode = MODE_TICK;
      end else if (esc_left > 0) begin
        esc_left--;
        if (esc_left == 0) it.rx_byte = ASCII_NEWLINE;
      end else begin
        r = $urandom_range(0, 99);
        if (r < esc_pct) begin
          it.rx_byte = ASCII_BACKSLASH;
          esc_left   = $urandom_range(1, 6);
        end else if (r < esc_pct + 3) begin
          it.rx_byte = ASCII_NEWLINE;
        end else if (it.rx_byte == ASCII_BACKSLASH) begin
          it.rx_byte = ~ASCII_BACKSLASH;
        end
      end
      byte_tick_q.push_back(it);
    end
  endtask

  task automatic wait_line_idle();
    do @(negedge clk_i);
    while (byte_tick_q.size() != 0 || in_valid_i || line_expect_q.size() != 0);
  endtask

  // item driver
  always @(posedge clk_i) begin : in_driver
    line_state_t want;
    logic        holding;
    if (rst_ni) begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        want = predict_line(cur_item);
        line_expect_q.push_back(want);
        holding = 1'b0;
        if (sender_eager) begin
          in_gap = 0;
        end else if (in_calm_left > 0) begin
          in_calm_left--;
          in_gap = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          in_calm_left = $urandom_range(20, 60);
          in_gap = 0;
        end else begin
          in_gap = pick_wait();
        end
      end
      if (!holding) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_tick_q.size() > 0) begin
          cur_item = byte_tick_q.pop_front();
          in_valid_i  <= 1'b1;
          mode_i      <= cur_item.mode;
          rx_byte_i   <= cur_item.rx_byte;
          char_code_i <= cur_item.char_code;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin : out_monitor
    line_state_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (line_expect_q.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          want = line_expect_q.pop_front();
          if (line_level_o !== want.line_level)
            report_mismatch($sformatf("line_level expected %0b got %0b",
                                      want.line_level, line_level_o));
          if (overflow_o !== want.overflow)
            report_mismatch($sformatf("overflow expected %0b got %0b",
                                      want.overflow, overflow_o));
          if (frame_busy_o !== want.frame_busy)
            report_mismatch($sformatf("frame_busy expected %0b got %0b",
                                      want.frame_busy, frame_busy_o));
        end
        results_seen++;
        if (out_calm_left > 0) begin
          out_calm_left--;
          out_hold = 0;
        end else if ($urandom_range(0, 39) == 0) begin
          out_calm_left = $urandom_range(20, 60);
          out_hold = 0;
        end else begin
          out_hold = pick_wait();
        end
      end
      // long hold-off so the block backs up into its input
      if (long_holds_done != long_holds_asked) begin
        long_holds_done = long_holds_asked;
        out_hold = LONG_HOLD;
      end
      if (out_hold > 0) begin
        out_hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("tb_top: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: timer held off, shift codes at their extremes
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFE0, 16'hFFFF);
    queue_item(MODE_TICK, 8'hFF, 7'h7F);
    queue_item(MODE_TICK, 8'h00, 7'h00);
    queue_item(MODE_TICK, 8'h00, 7'h00);
    // no case bit, both case bits with no case known, newline as text,
    // figures, bare frame, then a command that is thrown away
    queue_item(MODE_BYTE, 8'h00, 7'h00);
    queue_item(MODE_BYTE, 8'hFF, 7'h7F);
    queue_item(MODE_BYTE, ASCII_NEWLINE, 7'h20);
    queue_item(MODE_BYTE, 8'h41, 7'h40);
    queue_item(MODE_BYTE, 8'h42, 7'h1F);
    queue_item(MODE_BYTE, ASCII_BACKSLASH, 7'h7F);
    queue_item(MODE_BYTE, 8'h78, 7'h11);
    queue_item(MODE_BYTE, ASCII_BACKSLASH, 7'h22);
    queue_item(MODE_BYTE, ASCII_NEWLINE, 7'h33);
    queue_item(MODE_BYTE, 8'h55, 7'h2A);
    wait_line_idle();

    // compare dropped under the running count: fires on the next tick
    program_regs(16'd1, 16'd2, 16'd31, 16'd0);
    repeat (12) queue_item(MODE_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
    wait_line_idle();

    repeat (3) begin
      program_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      queue_phase(100, 65, 6);
      wait_line_idle();
    end

    // byte flood with the timer stopped: the buffer fills and drops
    program_regs(16'hFFFF, 16'hFFFF, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    queue_phase(140, 0, 0);
    wait_line_idle();

    repeat (2) begin
      program_regs(16'd1, 16'($urandom_range(1, 3)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      queue_phase(100, 80, 4);
      wait_line_idle();
    end

    // sender at full rate while the receiver holds off
    program_regs(16'($urandom_range(1, 4)), 16'd1, 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    sender_eager = 1'b1;
    queue_phase(80, 50, 4);
    long_holds_asked++;
    wait_line_idle();
    sender_eager = 1'b0;

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
